@@ src/vlv_pkg.sv @@
// ============================================================================
// vlv_pkg
// Shared types, constants and per-stage step functions for the
// velocity-limited Verlet step pipeline.
// ============================================================================
package vlv_pkg;

  localparam int VALUE_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int CNT_W       = 32;
  localparam int LIMIT_W     = 63;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  // pipeline depth of the iterative units, one bit or one root digit a stage
  localparam int KICK_STAGES = 63;
  localparam int LIM_STAGES  = 64;
  localparam int ROOT_STAGES = 32;
  // edges from the accepting edge until the strobe is sampled high
  localparam int LATENCY     = KICK_STAGES + LIM_STAGES + ROOT_STAGES + 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_NONE = {LIMIT_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX    = {CNT_W{1'b1}};

  localparam logic signed [65:0] SAT_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] SAT_MIN = -66'sh0_8000_0000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [31:0]        particle_mass;
    logic               in_group;
    logic               phase;
  } req_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               was_limited;
    logic [31:0]        limited_total;
  } res_t;

  // fields that travel with a request through every stage
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0]       fneg;
    logic             in_group;
    logic             phase;
    logic             limited;
    logic [31:0]      total;
  } carry_t;

  // kick divider: (scale * |f|) / mass, three lanes
  typedef struct packed {
    carry_t           c;
    logic [2:0][62:0] num;
    logic [2:0][31:0] rem;
    logic [2:0][62:0] quot;
    logic [31:0]      mass;
  } kdiv_t;

  // limit divider: limit * 2^64 / vsq
  typedef struct packed {
    carry_t      c;
    logic [63:0] vsq;
    logic [63:0] rem;
    logic [63:0] quot;
  } ldiv_t;

  // square root digit recurrence
  typedef struct packed {
    carry_t      c;
    logic [63:0] rem;
    logic [63:0] root;
  } root_t;

  function automatic logic [31:0] mag_of(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // signed add of a sign-magnitude delta with saturation to 32 bits
  function automatic logic [31:0] sat_add(logic [31:0] base, logic neg, logic [63:0] mag);
    logic signed [65:0] b;
    logic signed [65:0] d;
    logic signed [65:0] s;
    b = $signed({{34{base[31]}}, base});
    d = $signed({2'b00, mag});
    if (neg) d = -d;
    s = b + d;
    if (s > SAT_MAX) return 32'h7FFF_FFFF;
    else if (s < SAT_MIN) return 32'h8000_0000;
    else return s[31:0];
  endfunction

  // one restoring-division bit per lane
  function automatic kdiv_t kdiv_step(kdiv_t s, int bitpos);
    kdiv_t       r;
    logic [32:0] trial;
    logic [32:0] diff;
    r = s;
    for (int k = 0; k < 3; k++) begin
      trial = {s.rem[k], s.num[k][bitpos]};
      diff  = trial - {1'b0, s.mass};
      if (trial >= {1'b0, s.mass}) begin
        r.rem[k]          = diff[31:0];
        r.quot[k][bitpos] = 1'b1;
      end else begin
        r.rem[k] = trial[31:0];
      end
    end
    return r;
  endfunction

  // one quotient bit; the low numerator bits are all zero
  function automatic ldiv_t ldiv_step(ldiv_t s, int bitpos);
    ldiv_t       r;
    logic [64:0] trial;
    logic [64:0] diff;
    r     = s;
    trial = {s.rem, 1'b0};
    diff  = trial - {1'b0, s.vsq};
    if (trial >= {1'b0, s.vsq}) begin
      r.rem          = diff[63:0];
      r.quot[bitpos] = 1'b1;
    end else begin
      r.rem = trial[63:0];
    end
    return r;
  endfunction

  // one root digit, trial bit 4^(31-j)
  function automatic root_t root_step(root_t s, int j);
    root_t       r;
    logic [63:0] bitv;
    logic [63:0] t;
    r    = s;
    bitv = 64'd1 << (62 - 2 * j);
    t    = s.root + bitv;
    if (s.rem >= t) begin
      r.rem  = s.rem - t;
      r.root = (s.root >> 1) + bitv;
    end else begin
      r.root = s.root >> 1;
    end
    return r;
  endfunction

endpackage

@@ src/velocity_limited_verlet_step_unit.sv @@
// ============================================================================
// velocity_limited_verlet_step_unit
// Half-step velocity kick, speed limit and position drift for one particle
// per request, fully pipelined.
// ============================================================================
// Takes one particle request in every clock cycle (busy is only high during
// reset) and returns its result with done high for exactly one cycle;
// results leave in request order and the receiver cannot stall them. The
// pipeline is made up mostly of the 63-stage kick divider, the 64-stage
// limit divider and the 32-stage square root, each resolving one bit per
// stage. Configuration writes are always taken (cfg_ready is high) and must
// only happen with no request in flight.
module velocity_limited_verlet_step_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  vlv_pkg::req_t                      req,
  output logic                               done,
  output vlv_pkg::res_t                      res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vlv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vlv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [31:0]                   cfg_scale;
  logic [31:0]                   cfg_step;
  logic [vlv_pkg::LIMIT_W-1:0]   cfg_limit;
  logic [vlv_pkg::CNT_W-1:0]     limit_counter;
  logic [vlv_pkg::CNT_W-1:0]     limit_counter_next;

  logic [vlv_pkg::KICK_STAGES:0] kd_valid;
  vlv_pkg::kdiv_t                kd [vlv_pkg::KICK_STAGES+1];
  vlv_pkg::kdiv_t                kd_next;

  logic                          b_valid;
  vlv_pkg::carry_t               b_c;
  vlv_pkg::carry_t               b_next;
  logic                          c_valid;
  vlv_pkg::carry_t               c_c;
  logic [2:0][63:0]              c_sq;
  logic [2:0][63:0]              c_sq_next;
  logic                          d_valid;
  vlv_pkg::carry_t               d_c;
  logic [63:0]                   d_vsq;

  logic [vlv_pkg::LIM_STAGES:0]  ld_valid;
  vlv_pkg::ldiv_t                ld [vlv_pkg::LIM_STAGES+1];
  vlv_pkg::ldiv_t                ld_next;
  logic                          limit_hit;

  logic [vlv_pkg::ROOT_STAGES:0] rt_valid;
  vlv_pkg::root_t                rt [vlv_pkg::ROOT_STAGES+1];

  logic                          s_valid;
  vlv_pkg::carry_t               s_c;
  vlv_pkg::carry_t               s_next;
  logic                          m_valid;
  vlv_pkg::carry_t               m_c;
  logic [2:0][63:0]              m_dp;
  logic [2:0][63:0]              m_dp_next;
  vlv_pkg::res_t                 res_next;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_scale <= '0;
      cfg_step  <= '0;
      cfg_limit <= vlv_pkg::LIMIT_NONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vlv_pkg::CFG_FORCE_SCALE: cfg_scale <= cfg_data[31:0];
        vlv_pkg::CFG_TIME_STEP:   cfg_step  <= cfg_data[31:0];
        vlv_pkg::CFG_SPEED_LIMIT: cfg_limit <= cfg_data[vlv_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // entry stage: decode, kick numerator product, mass fixup
  always_comb begin
    logic [2:0][31:0] f;
    logic [63:0]      p;
    f = {req.force_z, req.force_y, req.force_x};
    kd_next            = '0;
    kd_next.c.pos      = {req.pos_z, req.pos_y, req.pos_x};
    kd_next.c.vel      = {req.vel_z, req.vel_y, req.vel_x};
    kd_next.c.in_group = req.in_group;
    kd_next.c.phase    = req.phase;
    kd_next.mass       = (req.particle_mass == '0) ? 32'd1 : req.particle_mass;
    for (int k = 0; k < 3; k++) begin
      p                  = cfg_scale * vlv_pkg::mag_of(f[k]);
      kd_next.c.fneg[k]  = f[k][31];
      kd_next.num[k]     = p[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) kd_valid[0] <= 1'b0;
    else     kd_valid[0] <= start && !busy;
    kd[0] <= kd_next;
  end

  // kick divider, one quotient bit per stage
  for (genvar j = 0; j < vlv_pkg::KICK_STAGES; j++) begin : g_kdiv
    always_ff @(posedge clk) begin
      if (rst) kd_valid[j+1] <= 1'b0;
      else     kd_valid[j+1] <= kd_valid[j];
      kd[j+1] <= vlv_pkg::kdiv_step(kd[j], vlv_pkg::KICK_STAGES - 1 - j);
    end
  end

  // velocity kick with saturation
  always_comb begin
    b_next = kd[vlv_pkg::KICK_STAGES].c;
    if (b_next.in_group) begin
      for (int k = 0; k < 3; k++) begin
        b_next.vel[k] = vlv_pkg::sat_add(b_next.vel[k], b_next.fneg[k],
                                         {1'b0, kd[vlv_pkg::KICK_STAGES].quot[k]});
      end
    end
  end

  // component squares
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_sq_next[k] = vlv_pkg::mag_of(b_c.vel[k]) * vlv_pkg::mag_of(b_c.vel[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      b_valid <= kd_valid[vlv_pkg::KICK_STAGES];
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
    b_c   <= b_next;
    c_c   <= b_c;
    c_sq  <= c_sq_next;
    d_c   <= c_c;
    d_vsq <= c_sq[0] + c_sq[1] + c_sq[2];
  end

  // limit compare and saturating count
  always_comb begin
    limit_hit = d_c.in_group && (cfg_limit != vlv_pkg::LIMIT_NONE) &&
                ({1'b0, cfg_limit} < d_vsq);
    limit_counter_next = limit_counter;
    if (d_valid && limit_hit && (limit_counter != vlv_pkg::CNT_MAX)) begin
      limit_counter_next = limit_counter + 32'd1;
    end
    ld_next           = '0;
    ld_next.c         = d_c;
    ld_next.c.limited = limit_hit;
    ld_next.c.total   = limit_counter_next;
    ld_next.vsq       = d_vsq;
    ld_next.rem       = limit_hit ? {1'b0, cfg_limit} : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_counter <= '0;
      ld_valid[0]   <= 1'b0;
    end else begin
      limit_counter <= limit_counter_next;
      ld_valid[0]   <= d_valid;
    end
    ld[0] <= ld_next;
  end

  // limit divider, one quotient bit per stage
  for (genvar j = 0; j < vlv_pkg::LIM_STAGES; j++) begin : g_ldiv
    always_ff @(posedge clk) begin
      if (rst) ld_valid[j+1] <= 1'b0;
      else     ld_valid[j+1] <= ld_valid[j];
      ld[j+1] <= vlv_pkg::ldiv_step(ld[j], vlv_pkg::LIM_STAGES - 1 - j);
    end
  end

  // square root entry
  always_ff @(posedge clk) begin
    if (rst) rt_valid[0] <= 1'b0;
    else     rt_valid[0] <= ld_valid[vlv_pkg::LIM_STAGES];
    rt[0].c    <= ld[vlv_pkg::LIM_STAGES].c;
    rt[0].rem  <= ld[vlv_pkg::LIM_STAGES].quot;
    rt[0].root <= '0;
  end

  // square root, one digit per stage
  for (genvar j = 0; j < vlv_pkg::ROOT_STAGES; j++) begin : g_root
    always_ff @(posedge clk) begin
      if (rst) rt_valid[j+1] <= 1'b0;
      else     rt_valid[j+1] <= rt_valid[j];
      rt[j+1] <= vlv_pkg::root_step(rt[j], j);
    end
  end

  // velocity scaling by the root fraction
  always_comb begin
    logic [63:0] sp;
    logic [31:0] m;
    s_next = rt[vlv_pkg::ROOT_STAGES].c;
    for (int k = 0; k < 3; k++) begin
      sp = vlv_pkg::mag_of(s_next.vel[k]) * rt[vlv_pkg::ROOT_STAGES].root[31:0];
      m  = sp[63:32];
      if (s_next.limited) begin
        s_next.vel[k] = s_next.vel[k][31] ? (~m + 32'd1) : m;
      end
    end
  end

  // drift products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_dp_next[k] = cfg_step * vlv_pkg::mag_of(s_c.vel[k]);
    end
  end

  // position update and result packing
  always_comb begin
    logic [2:0][31:0] p;
    p = m_c.pos;
    if (m_c.in_group && !m_c.phase) begin
      for (int k = 0; k < 3; k++) begin
        p[k] = vlv_pkg::sat_add(m_c.pos[k], m_c.vel[k][31], m_dp[k] >> vlv_pkg::FRAC_BITS);
      end
    end
    res_next.new_pos_x     = p[0];
    res_next.new_pos_y     = p[1];
    res_next.new_pos_z     = p[2];
    res_next.new_vel_x     = m_c.vel[0];
    res_next.new_vel_y     = m_c.vel[1];
    res_next.new_vel_z     = m_c.vel[2];
    res_next.was_limited   = m_c.limited;
    res_next.limited_total = m_c.total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      m_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      s_valid <= rt_valid[vlv_pkg::ROOT_STAGES];
      m_valid <= s_valid;
      done    <= m_valid;
    end
    s_c  <= s_next;
    m_c  <= s_c;
    m_dp <= m_dp_next;
    res  <= res_next;
  end

endmodule

@@ src/vlv_checker.sv @@
// ============================================================================
// vlv_checker
// Port-level timing and status checks for the Verlet step unit.
// ============================================================================
module vlv_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input vlv_pkg::res_t res
);

  // every strobe traces back to one request
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, vlv_pkg::LATENCY))
    else $error("result without matching request");

  // every request comes out after the fixed latency
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(vlv_pkg::LATENCY) done)
    else $error("request lost");

  // a limited particle is always counted
  a_count: assert property (@(posedge clk) disable iff (rst)
    (done && res.was_limited) |-> (res.limited_total != '0))
    else $error("limited particle not counted");

endmodule

bind velocity_limited_verlet_step_unit vlv_checker u_vlv_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .res   (res)
);

@@ tb/sv/tb_velocity_limited_verlet_step_unit.sv @@
// ============================================================================
// tb_velocity_limited_verlet_step_unit
// Self-checking bench for the Verlet half-step unit: drives particle requests
// with random gaps, predicts kick, speed limit and drift per request, and
// compares every strobed result against the oldest prediction.
// ============================================================================
module tb_velocity_limited_verlet_step_unit;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  vlv_pkg::req_t                  req = '0;
  logic                           done;
  vlv_pkg::res_t                  res;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [vlv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [vlv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  velocity_limited_verlet_step_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0]                 force_scale_q;
  logic [31:0]                 drift_step_q;
  logic [vlv_pkg::LIMIT_W-1:0] speed_limit_q;
  logic [31:0]                 limited_cnt_q;

  vlv_pkg::res_t particle_q[$];
  int            mismatches = 0;
  bit            no_gaps = 1'b0;

  // magnitude of a two's complement value
  function automatic logic [63:0] magnitude(logic [31:0] v);
    return v[31] ? (64'd0 - {{32{1'b1}}, v}) : {32'd0, v};
  endfunction

  // base plus signed delta, clamped to 32 bits
  function automatic logic [31:0] clamp_add(logic [31:0] base, logic neg, logic [63:0] mag);
    logic signed [67:0] s;
    logic signed [67:0] d;
    s = $signed({{36{base[31]}}, base});
    d = $signed({4'b0, mag});
    s = neg ? s - d : s + d;
    if (s > 68'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (s < -68'sh8000_0000) return 32'h8000_0000;
    return s[31:0];
  endfunction

  function automatic logic [63:0] root128(logic [127:0] n);
    logic [127:0] r;
    logic [127:0] b;
    r = '0;
    b = 128'd1 << 126;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[63:0];
  endfunction

  // expected result of one particle; advances the limit counter
  function automatic vlv_pkg::res_t verlet_predict(vlv_pkg::req_t r);
    vlv_pkg::res_t    o;
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
    logic [2:0][31:0] f;
    logic [63:0]      mass;
    logic [63:0]      m;
    logic [63:0]      s;
    logic [127:0]     vsq;
    logic [127:0]     num;
    p = {r.pos_x, r.pos_y, r.pos_z};
    v = {r.vel_x, r.vel_y, r.vel_z};
    f = {r.force_x, r.force_y, r.force_z};
    o.was_limited = 1'b0;
    if (r.in_group) begin
      mass = (r.particle_mass == 0) ? 64'd1 : {32'd0, r.particle_mass};
      vsq = '0;
      for (int k = 0; k < 3; k++) begin
        m = ({32'd0, force_scale_q} * magnitude(f[k])) / mass;
        v[k] = clamp_add(v[k], f[k][31], m);
        m = magnitude(v[k]);
        vsq = vsq + {64'd0, m * m};
      end
      if (speed_limit_q != vlv_pkg::LIMIT_NONE && {65'd0, speed_limit_q} < vsq) begin
        num = {1'b0, speed_limit_q, 64'd0};
        s = root128(num / vsq);
        for (int k = 0; k < 3; k++) begin
          m = (magnitude(v[k]) * s) >> 32;
          v[k] = clamp_add(32'd0, v[k][31], m);
        end
        o.was_limited = 1'b1;
        if (limited_cnt_q != vlv_pkg::CNT_MAX) limited_cnt_q++;
      end
      if (!r.phase) begin
        for (int k = 0; k < 3; k++) begin
          m = ({32'd0, drift_step_q} * magnitude(v[k])) >> vlv_pkg::FRAC_BITS;
          p[k] = clamp_add(p[k], v[k][31], m);
        end
      end
    end
    {o.new_pos_x, o.new_pos_y, o.new_pos_z} = p;
    {o.new_vel_x, o.new_vel_y, o.new_vel_z} = v;
    o.limited_total = limited_cnt_q;
    return o;
  endfunction

  // result checker: every strobe consumes the oldest prediction
  always @(posedge clk) begin
    vlv_pkg::res_t e;
    if (!rst && done) begin
      if (particle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res);
      end else begin
        e = particle_q.pop_front();
        if (res !== e) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch pos exp %h %h %h got %h %h %h", e.new_pos_x, e.new_pos_y,
                     e.new_pos_z, res.new_pos_x, res.new_pos_y, res.new_pos_z);
            $display("  vel exp %h %h %h got %h %h %h", e.new_vel_x, e.new_vel_y,
                     e.new_vel_z, res.new_vel_x, res.new_vel_y, res.new_vel_z);
            $display("  limited exp %b/%0d got %b/%0d", e.was_limited, e.limited_total,
                     res.was_limited, res.limited_total);
          end
        end
      end
    end
  end

  // one request; literal expectation when given, else predicted
  task automatic send_particle(vlv_pkg::req_t r, bit use_lit, vlv_pkg::res_t lit);
    vlv_pkg::res_t e;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    e = verlet_predict(r);
    particle_q = {particle_q, (use_lit ? lit : e)};
    if (!no_gaps && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (particle_q.size() != 0) @(posedge clk);
  endtask

  // write all three registers back to back while idle
  task automatic write_regs(logic [63:0] scale, logic [63:0] dt, logic [63:0] lim);
    logic [63:0] d[3];
    d = '{scale, dt, lim};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (vlv_pkg::CFG_IDX_W)'(i);
      cfg_data  <= d[i];
      do @(posedge clk); while (!cfg_ready);
      case ((vlv_pkg::CFG_IDX_W)'(i))
        vlv_pkg::CFG_FORCE_SCALE: force_scale_q = d[i][31:0];
        vlv_pkg::CFG_TIME_STEP:   drift_step_q  = d[i][31:0];
        vlv_pkg::CFG_SPEED_LIMIT: speed_limit_q = d[i][vlv_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] x;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: begin
        x = $urandom_range(0, 32'h3_FFFF);
        return $urandom_range(0, 1) ? -x : x;
      end
      7: return 32'h8000_0000;
      8: return 32'h7FFF_FFFF;
      default: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic vlv_pkg::req_t pick_particle();
    vlv_pkg::req_t r;
    r.pos_x = pick_value(); r.pos_y = pick_value(); r.pos_z = pick_value();
    r.vel_x = pick_value(); r.vel_y = pick_value(); r.vel_z = pick_value();
    r.force_x = pick_value(); r.force_y = pick_value(); r.force_z = pick_value();
    case ($urandom_range(0, 4))
      0: r.particle_mass = $urandom;
      1: r.particle_mass = 32'h1_0000;
      2: r.particle_mass = $urandom_range(0, 3);
      default: r.particle_mass = $urandom_range(1, 32'h4_0000);
    endcase
    r.in_group = $urandom_range(0, 9) < 8;
    r.phase    = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic vlv_pkg::req_t mk(logic [31:0] p, logic [31:0] v, logic [31:0] f,
                                       logic [31:0] mass, logic grp, logic ph);
    vlv_pkg::req_t r;
    r = '{p, -p, p, v, v, -v, f, -f, f, mass, grp, ph};
    return r;
  endfunction

  vlv_pkg::req_t reset_rows[6];
  vlv_pkg::req_t tuned_rows[8];
  vlv_pkg::req_t harsh_rows[4];

  initial begin
    vlv_pkg::res_t lit;
    vlv_pkg::req_t none;
    force_scale_q = '0;
    drift_step_q  = '0;
    speed_limit_q = vlv_pkg::LIMIT_NONE;
    limited_cnt_q = '0;
    none = '0;

    // after reset nothing moves: outputs echo inputs
    reset_rows = '{
      mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 0),
      mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 1, 0),
      mk(32'h0, 32'h0, 32'h0, 32'h0, 1, 1),
      mk(32'h1234_5678, 32'hFFFF_0000, 32'h0001_0000, 32'h1_0000, 0, 0),
      mk(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1_0000, 0, 1),
      mk(32'h0001_0000, 32'h0003_0000, 32'h7FFF_FFFF, 32'h1_0000, 1, 1)
    };
    // unit kick and drift, speed limit of 2.0
    tuned_rows = '{
      mk(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h1_0000, 1, 0),
      mk(32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h1_0000, 1, 0),
      mk(32'hFFF0_0000, 32'hFFFD_0000, 32'hFFFF_0000, 32'h1_0000, 1, 1),
      mk(32'h7FFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 1, 0),
      mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 1, 0),
      mk(32'h0000_0100, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1, 0),
      mk(32'h0002_0000, 32'h0005_0000, 32'h0004_0000, 32'h1_0000, 0, 0),
      mk(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1, 0)
    };
    // largest factors with a zero limit
    harsh_rows = '{
      mk(32'h0, 32'h0, 32'h0, 32'h1_0000, 1, 0),
      mk(32'h0001_0000, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 1, 0),
      mk(32'h7FFF_FFFF, 32'h0100_0000, 32'h0100_0000, 32'h1_0000, 1, 1),
      mk(32'h8000_0000, 32'hFF00_0000, 32'h8000_0000, 32'h0000_0001, 1, 0)
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (reset_rows[i]) begin
      lit = '{reset_rows[i].pos_x, reset_rows[i].pos_y, reset_rows[i].pos_z,
              reset_rows[i].vel_x, reset_rows[i].vel_y, reset_rows[i].vel_z, 1'b0, 32'd0};
      send_particle(reset_rows[i], 1'b1, lit);
    end
    drain();

    write_regs(64'hABCD_0000_0001_0000, 64'h1234_5678_0001_0000, 64'h4_0000_0000);
    foreach (tuned_rows[i]) send_particle(tuned_rows[i], 1'b0, lit);
    drain();

    write_regs(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'h0);
    foreach (harsh_rows[i]) send_particle(harsh_rows[i], 1'b0, lit);
    drain();

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_regs(64'h0000_8000, 64'h0000_4000, {$urandom_range(1, 64), 32'h0});
        1: write_regs(64'hFFFF_FFFF, 64'hFFFF_FFFF, {1'b0, vlv_pkg::LIMIT_NONE});
        2: write_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        3: write_regs(64'($urandom_range(0, 32'h2_0000)), 64'($urandom_range(0, 32'h2_0000)),
                      {1'b1, vlv_pkg::LIMIT_NONE - 63'd1});
        4: write_regs(64'($urandom_range(0, 32'h1_0000)), 64'h1_0000,
                      {$urandom_range(0, 1023), $urandom});
        default: write_regs(64'h0, 64'($urandom), 64'h0);
      endcase
      no_gaps = (ph == 4);
      repeat (285) send_particle(pick_particle(), 1'b0, lit);
      drain();
    end

    send_particle(none, 1'b0, lit);
    drain();
    repeat (vlv_pkg::LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && particle_q.size() == 0) begin
      $display("tb_velocity_limited_verlet_step_unit: PASS");
    end else begin
      $display("tb_velocity_limited_verlet_step_unit: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("tb_velocity_limited_verlet_step_unit: FAIL");
    $finish;
  end

endmodule
